@@ src/qrs_pkg.sv @@
// Shared item types, status codes and pipeline tag for the quadratic root solver.
package qrs_pkg;

   // Result status codes
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NEG_DISC = 2'd1;
   localparam logic [1:0] ST_A_ZERO   = 2'd2;
   localparam logic [1:0] ST_SAT      = 2'd3;

   typedef struct packed {
      logic signed [31:0] coef_a;
      logic signed [31:0] coef_b;
      logic signed [31:0] coef_c;
   } req_type;

   typedef struct packed {
      logic signed [31:0] root_plus;
      logic signed [31:0] root_minus;
      logic [1:0]         status;
   } rsp_type;

   // Flags that ride along the divider pipeline
   typedef struct packed {
      logic a_zero;
      logic d_neg;
      logic neg_p;
      logic neg_m;
   } tag_type;

endpackage

@@ src/quadratic_root_solver.sv @@
// Quadratic root solver top level: products, discriminant, square root, divide, saturate.
// Throughput: one item per cycle; busy stays low, every start is taken.
// Depth is set by the square root (WORD_BITS+1 stages) and divider (WORD_BITS+FRAC_BITS+1 stages).
// Reset clears every valid bit in the pipeline; data registers are not reset.
// Results are shown for one cycle on rsp_valid and cannot be held off.
module quadratic_root_solver
   import qrs_pkg::*;
#(
   parameter int WORD_BITS = 32,
   parameter int FRAC_BITS = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_valid,
   output rsp_type rsp_item
);
   localparam int W      = WORD_BITS;
   localparam int F      = FRAC_BITS;
   localparam int PW     = 2 * W;
   localparam int DW     = 2 * W + 1;
   localparam int RW     = W + 1;
   localparam int NW     = W + 1;
   localparam int QW     = NW + F;
   localparam int SIDE_W = 2 + 2 * W;
   localparam int LAT_S1 = RW + QW + 4;

   // Stage 1: capture coefficients
   logic                s1_valid_ff;
   logic signed [W-1:0] s1_a_ff, s1_b_ff, s1_c_ff;
   // Stage 2: products
   logic                s2_valid_ff;
   logic [PW-1:0]       s2_bsq_ff, s2_p_ff;
   logic                s2_a_zero_ff, s2_opp_ff;
   logic signed [W-1:0] s2_a_ff, s2_b_ff;
   // Stage 3: discriminant
   logic                s3_valid_ff;
   logic [DW-1:0]       s3_d_ff;
   logic                s3_a_zero_ff, s3_d_neg_ff;
   logic signed [W-1:0] s3_a_ff, s3_b_ff;
   // Square root outputs
   logic                sq_valid;
   logic [RW-1:0]       sq_root;
   logic [SIDE_W-1:0]   sq_side;
   logic                sq_a_zero, sq_d_neg;
   logic signed [W-1:0] sq_a, sq_b;
   // Stage 4: numerators and divisor
   logic                s4_valid_ff;
   logic [QW-1:0]       s4_num_p_ff, s4_num_m_ff;
   logic [W:0]          s4_den_ff;
   tag_type             s4_tag_ff;
   // Divider outputs
   logic                dv_valid;
   logic [QW-1:0]       dv_q_p, dv_q_m;
   tag_type             dv_tag;
   // Output register
   logic                rsp_valid_ff;
   rsp_type             rsp_ff, rsp_in;

   logic [W-1:0]        a_mag, b_mag, c_mag;
   logic [DW-1:0]       bsq_x, p4_x;
   logic                d_neg_in;
   logic signed [W+1:0] b_x, root_x, nump, numm;
   logic [NW-1:0]       mag_p, mag_m;
   logic [W-1:0]        sq_a_mag;
   tag_type             tag_in;
   logic [W:0]          fin_p, fin_m;
   logic signed [W-1:0] val_p, val_m;

   // Saturate a quotient magnitude and apply its sign; top bit flags saturation
   function automatic logic [W:0] sat_root(input logic [QW-1:0] q, input logic neg);
      logic [QW-1:0] lim;
      logic [QW-1:0] qc;
      logic          sat;
      lim = QW'(1) << (W - 1);
      if (neg) begin
         sat = q > lim;
         qc  = sat ? lim : q;
         qc  = ~qc + QW'(1);
      end else begin
         sat = q > (lim - QW'(1));
         qc  = sat ? (lim - QW'(1)) : q;
      end
      return {sat, qc[W-1:0]};
   endfunction

   assign busy = 1'b0;

   // Stage 1
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= start;
      end
   end

   always_ff @(posedge clock) begin
      s1_a_ff <= req_item.coef_a[W-1:0];
      s1_b_ff <= req_item.coef_b[W-1:0];
      s1_c_ff <= req_item.coef_c[W-1:0];
   end

   // Stage 2: magnitudes and products
   assign a_mag = s1_a_ff[W-1] ? (~unsigned'(s1_a_ff) + W'(1)) : unsigned'(s1_a_ff);
   assign b_mag = s1_b_ff[W-1] ? (~unsigned'(s1_b_ff) + W'(1)) : unsigned'(s1_b_ff);
   assign c_mag = s1_c_ff[W-1] ? (~unsigned'(s1_c_ff) + W'(1)) : unsigned'(s1_c_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_bsq_ff    <= PW'(b_mag) * PW'(b_mag);
      s2_p_ff      <= PW'(a_mag) * PW'(c_mag);
      s2_a_zero_ff <= (s1_a_ff == '0);
      s2_opp_ff    <= (s1_a_ff[W-1] != s1_c_ff[W-1]) || (s1_c_ff == '0);
      s2_a_ff      <= s1_a_ff;
      s2_b_ff      <= s1_b_ff;
   end

   // Stage 3: discriminant b*b -/+ 4*|a*c|
   assign bsq_x    = DW'(s2_bsq_ff);
   assign p4_x     = DW'({s2_p_ff, 2'b00});
   assign d_neg_in = !s2_opp_ff && (bsq_x < p4_x);

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s3_d_ff      <= s2_opp_ff ? (bsq_x + p4_x) : (bsq_x - p4_x);
      s3_a_zero_ff <= s2_a_zero_ff;
      s3_d_neg_ff  <= d_neg_in;
      s3_a_ff      <= s2_a_ff;
      s3_b_ff      <= s2_b_ff;
   end

   qrs_sqrt #(
      .D_W    (DW),
      .R_W    (RW),
      .SIDE_W (SIDE_W)
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s3_valid_ff),
      .in_rad    (s3_d_ff),
      .in_side   ({s3_a_zero_ff, s3_d_neg_ff, s3_a_ff, s3_b_ff}),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   assign {sq_a_zero, sq_d_neg, sq_a, sq_b} = sq_side;

   // Stage 4: numerators -b +/- root, signs and divisor 2|a|
   assign b_x      = (W+2)'(sq_b);
   assign root_x   = signed'({1'b0, sq_root});
   assign nump     = root_x - b_x;
   assign numm     = -root_x - b_x;
   assign mag_p    = nump[W+1] ? NW'(-nump) : NW'(nump);
   assign mag_m    = numm[W+1] ? NW'(-numm) : NW'(numm);
   assign sq_a_mag = sq_a[W-1] ? (~unsigned'(sq_a) + W'(1)) : unsigned'(sq_a);

   always_comb begin
      tag_in.a_zero = sq_a_zero;
      tag_in.d_neg  = sq_d_neg;
      tag_in.neg_p  = nump[W+1] != sq_a[W-1];
      tag_in.neg_m  = numm[W+1] != sq_a[W-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else begin
         s4_valid_ff <= sq_valid;
      end
   end

   always_ff @(posedge clock) begin
      s4_num_p_ff <= QW'(mag_p) << F;
      s4_num_m_ff <= QW'(mag_m) << F;
      s4_den_ff   <= {sq_a_mag, 1'b0};
      s4_tag_ff   <= tag_in;
   end

   qrs_div #(
      .Q_W   (QW),
      .DEN_W (W + 1)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s4_valid_ff),
      .in_num_p  (s4_num_p_ff),
      .in_num_m  (s4_num_m_ff),
      .in_den    (s4_den_ff),
      .in_tag    (s4_tag_ff),
      .out_valid (dv_valid),
      .out_q_p   (dv_q_p),
      .out_q_m   (dv_q_m),
      .out_tag   (dv_tag)
   );

   // Final: saturate, sign and pick status
   assign fin_p = sat_root(dv_q_p, dv_tag.neg_p);
   assign fin_m = sat_root(dv_q_m, dv_tag.neg_m);
   assign val_p = signed'(fin_p[W-1:0]);
   assign val_m = signed'(fin_m[W-1:0]);

   always_comb begin
      rsp_in.root_plus  = 32'(val_p);
      rsp_in.root_minus = 32'(val_m);
      rsp_in.status     = (fin_p[W] || fin_m[W]) ? ST_SAT : ST_OK;
      if (dv_tag.a_zero) begin
         rsp_in.root_plus  = '0;
         rsp_in.root_minus = '0;
         rsp_in.status     = ST_A_ZERO;
      end else if (dv_tag.d_neg) begin
         rsp_in.root_plus  = '0;
         rsp_in.root_minus = '0;
         rsp_in.status     = ST_NEG_DISC;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // An item in stage 1 reaches the output after a fixed depth
   assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> ##(LAT_S1) rsp_valid)
      else $error("item lost in pipeline");

   // Error statuses carry zero roots
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_item.status == ST_A_ZERO || rsp_item.status == ST_NEG_DISC)
      |-> (rsp_item.root_plus == '0 && rsp_item.root_minus == '0))
      else $error("nonzero roots with error status");

   // A zero coefficient a never reports a discriminant result
   assert property (@(posedge clock) disable iff (reset)
      dv_valid && dv_tag.a_zero |=> rsp_item.status == ST_A_ZERO)
      else $error("zero a not reported");

endmodule

@@ src/qrs_sqrt.sv @@
// Pipelined integer square root, one result bit per register stage.
module qrs_sqrt
   import qrs_pkg::*;
#(
   parameter int D_W    = 65,
   parameter int R_W    = 33,
   parameter int SIDE_W = 66
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [D_W-1:0]    in_rad,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [R_W-1:0]    out_root,
   output logic [SIDE_W-1:0] out_side
);
   localparam int X_W = 2 * R_W + 1;

   logic              valid_ff [R_W];
   logic [X_W-1:0]    rem_ff   [R_W];
   logic [R_W-1:0]    root_ff  [R_W];
   logic [SIDE_W-1:0] side_ff  [R_W];

   for (genvar s = 0; s < R_W; s++) begin : g_stage
      localparam int BIT = R_W - 1 - s;
      logic              pv;
      logic [X_W-1:0]    prem;
      logic [R_W-1:0]    proot;
      logic [SIDE_W-1:0] pside;
      logic [X_W-1:0]    trial;
      logic [X_W-1:0]    rem_in;
      logic [R_W-1:0]    root_in;

      if (s == 0) begin : g_first
         assign pv    = in_valid;
         assign prem  = X_W'(in_rad);
         assign proot = '0;
         assign pside = in_side;
      end else begin : g_next
         assign pv    = valid_ff[s-1];
         assign prem  = rem_ff[s-1];
         assign proot = root_ff[s-1];
         assign pside = side_ff[s-1];
      end

      // Try this bit: (root + 2^BIT)^2 - root^2
      assign trial = (X_W'(proot) << (BIT + 1)) + (X_W'(1) << (2 * BIT));

      always_comb begin
         rem_in  = prem;
         root_in = proot;
         if (prem >= trial) begin
            rem_in       = prem - trial;
            root_in[BIT] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else begin
            valid_ff[s] <= pv;
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[s]  <= rem_in;
         root_ff[s] <= root_in;
         side_ff[s] <= pside;
      end
   end

   assign out_valid = valid_ff[R_W-1];
   assign out_root  = root_ff[R_W-1];
   assign out_side  = side_ff[R_W-1];

endmodule

@@ src/qrs_div.sv @@
// Pipelined two-lane restoring divider with a shared divisor, one quotient bit per stage.
module qrs_div
   import qrs_pkg::*;
#(
   parameter int Q_W   = 49,
   parameter int DEN_W = 33
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic [Q_W-1:0]   in_num_p,
   input  logic [Q_W-1:0]   in_num_m,
   input  logic [DEN_W-1:0] in_den,
   input  tag_type          in_tag,
   output logic             out_valid,
   output logic [Q_W-1:0]   out_q_p,
   output logic [Q_W-1:0]   out_q_m,
   output tag_type          out_tag
);
   logic             valid_ff [Q_W];
   logic [Q_W-1:0]   num_p_ff [Q_W];
   logic [Q_W-1:0]   num_m_ff [Q_W];
   logic [DEN_W-1:0] rem_p_ff [Q_W];
   logic [DEN_W-1:0] rem_m_ff [Q_W];
   logic [Q_W-1:0]   q_p_ff   [Q_W];
   logic [Q_W-1:0]   q_m_ff   [Q_W];
   logic [DEN_W-1:0] den_ff   [Q_W];
   tag_type          tag_ff   [Q_W];

   for (genvar s = 0; s < Q_W; s++) begin : g_stage
      localparam int BIT = Q_W - 1 - s;
      logic             pv;
      logic [Q_W-1:0]   pnum_p;
      logic [Q_W-1:0]   pnum_m;
      logic [DEN_W-1:0] prem_p;
      logic [DEN_W-1:0] prem_m;
      logic [Q_W-1:0]   pq_p;
      logic [Q_W-1:0]   pq_m;
      logic [DEN_W-1:0] pden;
      tag_type          ptag;
      logic [DEN_W:0]   part_p;
      logic [DEN_W:0]   part_m;
      logic [DEN_W:0]   den_x;
      logic [DEN_W-1:0] rem_p_in;
      logic [DEN_W-1:0] rem_m_in;
      logic [Q_W-1:0]   q_p_in;
      logic [Q_W-1:0]   q_m_in;

      if (s == 0) begin : g_first
         assign pv     = in_valid;
         assign pnum_p = in_num_p;
         assign pnum_m = in_num_m;
         assign prem_p = '0;
         assign prem_m = '0;
         assign pq_p   = '0;
         assign pq_m   = '0;
         assign pden   = in_den;
         assign ptag   = in_tag;
      end else begin : g_next
         assign pv     = valid_ff[s-1];
         assign pnum_p = num_p_ff[s-1];
         assign pnum_m = num_m_ff[s-1];
         assign prem_p = rem_p_ff[s-1];
         assign prem_m = rem_m_ff[s-1];
         assign pq_p   = q_p_ff[s-1];
         assign pq_m   = q_m_ff[s-1];
         assign pden   = den_ff[s-1];
         assign ptag   = tag_ff[s-1];
      end

      // Bring down the next dividend bit in both lanes
      assign part_p = {prem_p, pnum_p[BIT]};
      assign part_m = {prem_m, pnum_m[BIT]};
      assign den_x  = {1'b0, pden};

      always_comb begin
         rem_p_in = part_p[DEN_W-1:0];
         rem_m_in = part_m[DEN_W-1:0];
         q_p_in   = pq_p;
         q_m_in   = pq_m;
         if (part_p >= den_x) begin
            rem_p_in    = DEN_W'(part_p - den_x);
            q_p_in[BIT] = 1'b1;
         end
         if (part_m >= den_x) begin
            rem_m_in    = DEN_W'(part_m - den_x);
            q_m_in[BIT] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else begin
            valid_ff[s] <= pv;
         end
      end

      always_ff @(posedge clock) begin
         num_p_ff[s] <= pnum_p;
         num_m_ff[s] <= pnum_m;
         rem_p_ff[s] <= rem_p_in;
         rem_m_ff[s] <= rem_m_in;
         q_p_ff[s]   <= q_p_in;
         q_m_ff[s]   <= q_m_in;
         den_ff[s]   <= pden;
         tag_ff[s]   <= ptag;
      end
   end

   assign out_valid = valid_ff[Q_W-1];
   assign out_q_p   = q_p_ff[Q_W-1];
   assign out_q_m   = q_m_ff[Q_W-1];
   assign out_tag   = tag_ff[Q_W-1];

endmodule
